>>> sv/des_pkg.sv
// ----------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes, key schedule and round functions for DES.
// ----------------------------------------------------------------------------
package des_pkg;

   localparam int ROUND_COUNT_DEFAULT = 16;
   localparam int HALF_KEY_BITS       = 28;
   localparam int HALF_BLOCK_BITS     = 32;
   localparam int BLOCK_BITS          = 64;
   localparam int CSR_INDEX_BITS      = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KEY_ONE      = 3'd0,
      CSR_KEY_TWO      = 3'd1,
      CSR_KEY_THREE    = 3'd2,
      CSR_DECRYPT_MODE = 3'd3,
      CSR_TRIPLE_MODE  = 3'd4
   } csr_index_type;

   typedef logic [BLOCK_BITS-1:0] block_type;
   typedef logic [47:0]           round_key_type;

   localparam logic [6:0] TAB_IP [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
      64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam logic [6:0] TAB_FP [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
      37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam logic [5:0] TAB_E [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam logic [5:0] TAB_P [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam logic [6:0] TAB_PC1 [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4};
   localparam logic [5:0] TAB_PC2 [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   // Total left rotation of the key halves after each round.
   localparam logic [4:0] TAB_CUM_SHIFT [16] = '{
      1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
   localparam logic [3:0] TAB_S [512] = '{
      14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
      15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
      10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
      7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
      2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
      12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
      4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
      13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,11,5,0,6,3,9};

   function automatic logic [27:0] rotl28(logic [27:0] x, logic [4:0] s);
      logic [27:0] y;
      y = (x << s) | (x >> (5'd28 - s));
      return y;
   endfunction

   // Round key for a fixed round index: pure wiring from the key.
   function automatic round_key_type round_key(block_type key, int idx);
      logic [55:0]   cd;
      logic [27:0]   c;
      logic [27:0]   d;
      round_key_type rk;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
      c  = rotl28(cd[55:28], TAB_CUM_SHIFT[idx]);
      d  = rotl28(cd[27:0], TAB_CUM_SHIFT[idx]);
      cd = {c, d};
      for (int i = 0; i < 48; i++) rk[47-i] = cd[56-TAB_PC2[i]];
      return rk;
   endfunction

   function automatic logic [31:0] feistel(logic [31:0] r, round_key_type rk);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
      x = x ^ rk;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = TAB_S[i*64 + {six[5], six[0]}*16 + six[4:1]];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
      return p;
   endfunction

   // One round; the first round of a pass applies IP, the last swaps and applies FP.
   function automatic block_type round_stage(block_type blk, round_key_type rk,
                                             bit first, bit last);
      block_type   x;
      block_type   y;
      block_type   z;
      logic [31:0] nr;
      if (first) begin
         for (int i = 0; i < 64; i++) x[63-i] = blk[64-TAB_IP[i]];
      end else begin
         x = blk;
      end
      nr = x[63:32] ^ feistel(x[31:0], rk);
      if (last) begin
         z = {nr, x[31:0]};
         for (int i = 0; i < 64; i++) y[63-i] = z[64-TAB_FP[i]];
      end else begin
         y = {x[31:0], nr};
      end
      return y;
   endfunction

endpackage

>>> sv/des_if.sv
// ----------------------------------------------------------------------------
// DES stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
interface des_req_if;
   logic                  valid;
   logic                  ready;
   des_pkg::block_type    data_block;
   modport source (output valid, output data_block, input ready);
   modport sink   (input valid, input data_block, output ready);
endinterface

interface des_rsp_if;
   logic                  valid;
   logic                  ready;
   des_pkg::block_type    result_block;
   modport source (output valid, output result_block, input ready);
   modport sink   (input valid, input result_block, output ready);
endinterface

>>> sv/des_triple_des_block_cipher.sv
// ----------------------------------------------------------------------------
// DES / triple DES (EEE3) block cipher, ECB
// Fully unrolled round pipeline, one stage per round over three passes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  req_if   in         data_block, 64-bit block to encrypt or decrypt
//  rsp_if   out        result_block, 64-bit processed block
//  csr_*    in         key_one, key_two, key_three, decrypt_mode, triple_mode
//
//  One item enters per cycle while the output is not stalled; the round
//  count is clamped to 1..16, one register stage per Feistel round. In single
//  mode the second and third passes carry the block through unchanged.
//  Reset empties the pipeline and zeroes the keys.
//  A stalled output holds every stage that is full; bubbles still close up.
// ----------------------------------------------------------------------------
module des_triple_des_block_cipher #(
   parameter int ROUND_COUNT = des_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   des_req_if.sink                              req_if,
   des_rsp_if.source                            rsp_if,
   input  logic                                 csr_we,
   input  logic [des_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [des_pkg::BLOCK_BITS-1:0]       csr_wdata
);
   localparam int ROUNDS_USED = (ROUND_COUNT < 1) ? 1 :
                                ((ROUND_COUNT > 16) ? 16 : ROUND_COUNT);
   localparam int STAGES = 3 * ROUNDS_USED;

   des_pkg::block_type key_ff [3];
   logic               decrypt_ff;
   logic               triple_ff;

   des_pkg::block_type data_ff  [STAGES];
   des_pkg::block_type data_in  [STAGES];
   logic               valid_ff [STAGES];
   logic [STAGES:0]    ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0]  <= '0;
         key_ff[1]  <= '0;
         key_ff[2]  <= '0;
         decrypt_ff <= 1'b0;
         triple_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            des_pkg::CSR_KEY_ONE:      key_ff[0]  <= csr_wdata;
            des_pkg::CSR_KEY_TWO:      key_ff[1]  <= csr_wdata;
            des_pkg::CSR_KEY_THREE:    key_ff[2]  <= csr_wdata;
            des_pkg::CSR_DECRYPT_MODE: decrypt_ff <= csr_wdata[0];
            des_pkg::CSR_TRIPLE_MODE:  triple_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign ready[STAGES] = rsp_if.ready;
   assign req_if.ready  = ready[0];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam int PASS  = i / ROUNDS_USED;
      localparam int ROUND = i % ROUNDS_USED;

      des_pkg::block_type     prev_data;
      logic                   prev_valid;
      des_pkg::block_type     key;
      des_pkg::round_key_type rk;
      logic                   active;

      if (i == 0) begin : g_head
         assign prev_data  = req_if.data_block;
         assign prev_valid = req_if.valid;
      end else begin : g_body
         assign prev_data  = data_ff[i-1];
         assign prev_valid = valid_ff[i-1];
      end

      // Triple decryption takes the keys in reverse order.
      always_comb begin
         if (!triple_ff)      key = key_ff[0];
         else if (decrypt_ff) key = key_ff[2-PASS];
         else                 key = key_ff[PASS];
      end

      assign rk = decrypt_ff ? des_pkg::round_key(key, ROUNDS_USED - 1 - ROUND)
                             : des_pkg::round_key(key, ROUND);
      assign active = (PASS == 0) || triple_ff;
      assign data_in[i] = active
         ? des_pkg::round_stage(prev_data, rk, ROUND == 0, ROUND == ROUNDS_USED - 1)
         : prev_data;
      assign ready[i] = !valid_ff[i] || ready[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[i]) begin
            data_ff[i] <= data_in[i];
         end
      end
   end

   assign rsp_if.valid        = valid_ff[STAGES-1];
   assign rsp_if.result_block = data_ff[STAGES-1];

endmodule

>>> sv/des_checker.sv
// ----------------------------------------------------------------------------
// DES port checker
// Watches the cipher's channels and reports handshake and flow faults.
// ----------------------------------------------------------------------------
module des_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input des_pkg::block_type result_block
);
   // The pipeline is emptied by reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A waiting result stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_block))
      else $error("waiting result changed or withdrawn");

   // Input back-pressure only comes from a full pipeline behind a blocked output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // An item offered to an idle output path is taken.
   a_take_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("item refused while output empty");
endmodule

bind des_triple_des_block_cipher des_checker u_des_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .result_block (rsp_if.result_block)
);

>>> bench/des_triple_des_block_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DES block cipher result checker
// Tracks the key and mode registers from the configuration port, predicts the
// cipher block for every accepted input item and compares it with the results.
// ----------------------------------------------------------------------------
module des_triple_des_block_cipher_checker (
   input  logic                                clock,
   input  logic                                reset,
   des_req_if                                  req_if,
   des_rsp_if                                  rsp_if,
   input  logic                                csr_we,
   input  logic [des_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [des_pkg::BLOCK_BITS-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  blocks_in_flight
);
   localparam int ROUNDS = 16;

   des_pkg::block_type     key_reg [3];
   logic                   decrypt_reg;
   logic                   triple_reg;
   des_pkg::round_key_type sched [3][16];
   des_pkg::block_type     cipher_queue [$];

   function automatic des_pkg::round_key_type subkey_of(des_pkg::block_type key, int r);
      logic [55:0]            cd;
      logic [27:0]            c;
      logic [27:0]            d;
      des_pkg::round_key_type k;
      int                     sh;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-des_pkg::TAB_PC1[i]];
      c  = cd[55:28];
      d  = cd[27:0];
      sh = des_pkg::TAB_CUM_SHIFT[r];
      c  = (c << sh) | (c >> (28 - sh));
      d  = (d << sh) | (d >> (28 - sh));
      cd = {c, d};
      for (int i = 0; i < 48; i++) k[47-i] = cd[56-des_pkg::TAB_PC2[i]];
      return k;
   endfunction

   function automatic logic [31:0] mangle(logic [31:0] r, des_pkg::round_key_type k);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  g;
      int          row;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-des_pkg::TAB_E[i]];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         g   = x[47-6*i -: 6];
         row = g[5] * 2 + g[0];
         s[31-4*i -: 4] = des_pkg::TAB_S[i*64 + row*16 + g[4:1]];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-des_pkg::TAB_P[i]];
      return p;
   endfunction

   function automatic des_pkg::block_type single_pass(des_pkg::block_type blk, int slot,
                                                      logic dec);
      des_pkg::block_type x;
      des_pkg::block_type y;
      logic [31:0]        l;
      logic [31:0]        r;
      logic [31:0]        t;
      for (int i = 0; i < 64; i++) x[63-i] = blk[64-des_pkg::TAB_IP[i]];
      l = x[63:32];
      r = x[31:0];
      for (int j = 0; j < ROUNDS; j++) begin
         t = l ^ mangle(r, sched[slot][dec ? ROUNDS-1-j : j]);
         l = r;
         r = t;
      end
      x = {r, l};
      for (int i = 0; i < 64; i++) y[63-i] = x[64-des_pkg::TAB_FP[i]];
      return y;
   endfunction

   function automatic des_pkg::block_type cipher_of(des_pkg::block_type blk);
      des_pkg::block_type b;
      b = blk;
      if (!triple_reg) begin
         b = single_pass(b, 0, decrypt_reg);
      end else if (decrypt_reg) begin
         b = single_pass(b, 2, 1'b1);
         b = single_pass(b, 1, 1'b1);
         b = single_pass(b, 0, 1'b1);
      end else begin
         b = single_pass(b, 0, 1'b0);
         b = single_pass(b, 1, 1'b0);
         b = single_pass(b, 2, 1'b0);
      end
      return b;
   endfunction

   task automatic load_key(int slot, des_pkg::block_type key);
      key_reg[slot] = key;
      for (int r = 0; r < 16; r++) sched[slot][r] = subkey_of(key, r);
   endtask

   initial begin
      fail_count       = 0;
      blocks_in_flight = 0;
      for (int s = 0; s < 3; s++) load_key(s, '0);
      decrypt_reg = 1'b0;
      triple_reg  = 1'b0;
   end

   always @(posedge clock) begin
      des_pkg::block_type want;
      if (reset) begin
         cipher_queue.delete();
         for (int s = 0; s < 3; s++) load_key(s, '0);
         decrypt_reg = 1'b0;
         triple_reg  = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            cipher_queue.insert(cipher_queue.size(), cipher_of(req_if.data_block));
         if (rsp_if.valid && rsp_if.ready) begin
            if (cipher_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result block %h", $time, rsp_if.result_block);
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_if.result_block !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result_block expected %h, got %h", $time, want,
                              rsp_if.result_block);
               end
            end
         end
         // Register writes take effect after this edge, so items accepted here use old keys.
         if (csr_we) begin
            unique case (csr_index)
               des_pkg::CSR_KEY_ONE:      load_key(0, csr_wdata);
               des_pkg::CSR_KEY_TWO:      load_key(1, csr_wdata);
               des_pkg::CSR_KEY_THREE:    load_key(2, csr_wdata);
               des_pkg::CSR_DECRYPT_MODE: decrypt_reg = csr_wdata[0];
               des_pkg::CSR_TRIPLE_MODE:  triple_reg = csr_wdata[0];
               default: ;
            endcase
         end
      end
      blocks_in_flight = cipher_queue.size();
   end

endmodule

>>> bench/des_triple_des_block_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DES block cipher testbench
// Drives blocks under single and triple DES in both directions with several
// key settings and handshake pressures; a checker compares every result.
// ----------------------------------------------------------------------------
module des_triple_des_block_cipher_tb;

   localparam logic [des_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 300000;

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [des_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [des_pkg::BLOCK_BITS-1:0]     csr_wdata;
   int                                 fail_count;
   int                                 blocks_in_flight;
   int                                 send_idle_pct;
   int                                 stall_pct;
   int                                 cycle_count;

   des_req_if req_if ();
   des_rsp_if rsp_if ();

   des_triple_des_block_cipher uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   des_triple_des_block_cipher_checker checker_inst (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .blocks_in_flight(blocks_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = des_pkg::CSR_KEY_ONE;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.data_block = '0;
      rsp_if.ready     = 1'b0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      cycle_count      = 0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= stall_pct);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** des_triple_des_block_cipher: FAILED **");
         $finish;
      end
   end

   function automatic des_pkg::block_type any_block();
      return {$urandom, $urandom};
   endfunction

   task automatic send_block(des_pkg::block_type blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.data_block <= blk;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // The first edge lets the checker count the item accepted just before.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (blocks_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes every register back to back; the mode values carry junk above bit 0.
   task automatic configure(des_pkg::block_type k1, des_pkg::block_type k2,
                            des_pkg::block_type k3, logic dec, logic tri_on);
      des_pkg::csr_index_type idx [5];
      des_pkg::block_type     val [5];
      idx = '{des_pkg::CSR_KEY_ONE, des_pkg::CSR_KEY_TWO, des_pkg::CSR_KEY_THREE,
              des_pkg::CSR_DECRYPT_MODE, des_pkg::CSR_TRIPLE_MODE};
      val = '{k1, k2, k3, {63'(any_block() >> 1), dec}, {63'(any_block() >> 1), tri_on}};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      // A write to an unused index must leave the keys alone.
      csr_index <= CSR_UNUSED;
      csr_wdata <= any_block();
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      des_pkg::block_type ones;
      ones = '1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: all-zero keys from reset first, then extreme keys and modes.
      send_block('0);
      send_block(ones);
      drain();
      configure(64'h1334_5779_9BBC_DFF1, ones, '0, 1'b0, 1'b0);
      send_block(64'h0123_4567_89AB_CDEF);
      send_block('0);
      send_block(ones);
      send_block(64'hAAAA_AAAA_AAAA_AAAA);
      send_block(64'h5555_5555_5555_5555);
      drain();
      configure(64'h1334_5779_9BBC_DFF1, ones, '0, 1'b1, 1'b0);
      send_block(64'h85E8_1354_0F0A_B405);
      send_block(ones);
      drain();
      // Parity bits only differ between these two keys.
      configure(64'h0101_0101_0101_0101, ones, '0, 1'b0, 1'b0);
      send_block(64'h8000_0000_0000_0000);
      send_block(64'h0000_0000_0000_0001);
      drain();
      configure('0, ones, '0, 1'b0, 1'b0);
      send_block(64'h8000_0000_0000_0000);
      send_block(64'h0000_0000_0000_0001);
      drain();
      configure(ones, '0, 64'hFEFE_FEFE_FEFE_FEFE, 1'b0, 1'b1);
      send_block('0);
      send_block(ones);
      send_block(64'h0123_4567_89AB_CDEF);
      drain();
      configure(ones, '0, 64'hFEFE_FEFE_FEFE_FEFE, 1'b1, 1'b1);
      send_block('0);
      send_block(ones);
      send_block(64'h0123_4567_89AB_CDEF);
      drain();

      // Random part: each handshake pressure under every mode combination.
      for (int ph = 0; ph < 16; ph++) begin
         unique case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 86; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 86; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         configure(any_block(), any_block(), any_block(), ph[2], ph[3]);
         for (int n = 0; n < 52; n++) send_block(any_block());
         drain();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && blocks_in_flight == 0) begin
         $display("** des_triple_des_block_cipher: PASSED **");
      end else begin
         $display("** des_triple_des_block_cipher: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/des_pkg.sv
sv/des_if.sv
sv/des_triple_des_block_cipher.sv
sv/des_checker.sv
bench/des_triple_des_block_cipher_checker.sv
bench/des_triple_des_block_cipher_tb.sv
